>>> src/dtf_pkg.sv
// ----------------------------------------------------------------------------
// dtf_pkg
// Types, constants and the month length table shared by the day count to
// FAT timestamp converter.
// ----------------------------------------------------------------------------
package dtf_pkg;

  localparam int unsigned EpochYear   = 1978;
  localparam int unsigned FatBaseYear = 1980;

  // Residues of the epoch year, used to seed the leap counters.
  localparam logic [1:0] EpochMod4   = 2'(EpochYear % 4);
  localparam logic [6:0] EpochMod100 = 7'(EpochYear % 100);
  localparam logic [8:0] EpochMod400 = 9'(EpochYear % 400);

  localparam logic [8:0] DaysYear     = 9'd365;
  localparam logic [8:0] DaysLeapYear = 9'd366;

  localparam logic [3:0] MonthJan = 4'd1;
  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [3:0] MonthApr = 4'd4;
  localparam logic [3:0] MonthJun = 4'd6;
  localparam logic [3:0] MonthSep = 4'd9;
  localparam logic [3:0] MonthNov = 4'd11;
  localparam logic [3:0] MonthDec = 4'd12;

  typedef struct packed {
    logic [15:0] day_count;
    logic [7:0]  hour_bcd;
    logic [7:0]  minute_bcd;
    logic [7:0]  second_bcd;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  day_of_month;
    logic [3:0]  month_number;
    logic [11:0] year_number;
    logic [15:0] fat_date;
    logic [15:0] fat_time;
  } out_item_t;

  // Control from the sequencer to the year tracker.
  typedef struct packed {
    logic init;
    logic step;
  } year_ctrl_t;

  function automatic logic [8:0] month_len(input logic [3:0] month, input logic leap);
    logic [8:0] len;
    begin
      len = 9'd31;
      if (month == MonthApr || month == MonthJun || month == MonthSep ||
          month == MonthNov) begin
        len = 9'd30;
      end else if (month == MonthFeb) begin
        len = leap ? 9'd29 : 9'd28;
      end
      return len;
    end
  endfunction

endpackage

>>> src/dtf_year.sv
// ----------------------------------------------------------------------------
// dtf_year
// Year counter with mod 4, 100 and 400 residues for the Gregorian leap test.
// ----------------------------------------------------------------------------
module dtf_year (
  input  logic                clk,
  input  logic                rst_n,
  input  dtf_pkg::year_ctrl_t ctrl,
  output logic [11:0]         year,
  output logic                leap
);
  import dtf_pkg::*;

  logic [11:0] year_r, year_nxt;
  logic [1:0]  m4_r, m4_nxt;
  logic [6:0]  m100_r, m100_nxt;
  logic [8:0]  m400_r, m400_nxt;

  always_comb begin
    year_nxt = year_r;
    m4_nxt   = m4_r;
    m100_nxt = m100_r;
    m400_nxt = m400_r;
    if (ctrl.init) begin
      year_nxt = 12'(EpochYear);
      m4_nxt   = EpochMod4;
      m100_nxt = EpochMod100;
      m400_nxt = EpochMod400;
    end else if (ctrl.step) begin
      year_nxt = year_r + 12'd1;
      m4_nxt   = m4_r + 2'd1;
      m100_nxt = (m100_r == 7'd99)  ? 7'd0 : m100_r + 7'd1;
      m400_nxt = (m400_r == 9'd399) ? 9'd0 : m400_r + 9'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_r <= 12'(EpochYear);
      m4_r   <= EpochMod4;
      m100_r <= EpochMod100;
      m400_r <= EpochMod400;
    end else begin
      year_r <= year_nxt;
      m4_r   <= m4_nxt;
      m100_r <= m100_nxt;
      m400_r <= m400_nxt;
    end
  end

  assign year = year_r;
  assign leap = ((m4_r == 2'd0) && (m100_r != 7'd0)) || (m400_r == 9'd0);

endmodule

>>> src/dtf_sub.sv
// ----------------------------------------------------------------------------
// dtf_sub
// Shared compare and subtract unit: takes a year or month length off the
// remaining day count when the count exceeds it.
// ----------------------------------------------------------------------------
module dtf_sub (
  input  logic [15:0] left,
  input  logic [8:0]  len,
  output logic        gt,
  output logic [15:0] diff
);
  import dtf_pkg::*;

  logic [16:0] d;

  assign d    = {1'b0, left} - {8'd0, len};
  // left > len exactly when left - len neither borrows nor is zero
  assign gt   = !d[16] && (d[15:0] != 16'd0);
  assign diff = d[15:0];

endmodule

>>> src/dtf_pack.sv
// ----------------------------------------------------------------------------
// dtf_pack
// BCD conversion and FAT date/time word packing.
// ----------------------------------------------------------------------------
module dtf_pack (
  input  logic [15:0]       left,
  input  logic [3:0]        month,
  input  logic [11:0]       year,
  input  dtf_pkg::in_item_t item,
  output dtf_pkg::out_item_t res
);
  import dtf_pkg::*;

  function automatic logic [7:0] bcd_bin(input logic [7:0] b);
    logic [7:0] hi;
    begin
      hi = {4'd0, b[7:4]};
      return (hi << 3) + (hi << 1) + {4'd0, b[3:0]};
    end
  endfunction

  logic [7:0]  hour_v, min_v, sec_v;
  logic [11:0] yoff;

  assign hour_v = bcd_bin(item.hour_bcd);
  assign min_v  = bcd_bin(item.minute_bcd);
  assign sec_v  = bcd_bin(item.second_bcd);
  assign yoff   = year - 12'(FatBaseYear);

  assign res.day_of_month = left[4:0];
  assign res.month_number = month;
  assign res.year_number  = year;
  assign res.fat_date     = left + {7'd0, month, 5'd0} + {yoff[6:0], 9'd0};
  assign res.fat_time     = {9'd0, sec_v[7:1]} + {3'd0, min_v, 5'd0} +
                            {hour_v[4:0], 11'd0};

endmodule

>>> src/day_count_to_fat_timestamp.sv
// ----------------------------------------------------------------------------
// day_count_to_fat_timestamp
// Converts a day count (day 1 = 1 Jan 1978) and BCD time into day, month,
// year and packed FAT date and time words.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. The result appears on
// out_item for exactly one cycle with out_valid high; the receiver cannot
// stall it. One compare/subtract unit removes one year per cycle, then one
// month per cycle: it takes off 0 to 179 whole years and then 0 to 11
// whole months. busy drops in the cycle the result is shown, so the next
// item may start then.
// ----------------------------------------------------------------------------
module day_count_to_fat_timestamp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  dtf_pkg::in_item_t   in_item,
  output logic                out_valid,
  output dtf_pkg::out_item_t  out_item
);
  import dtf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_YEAR,
    S_MONTH
  } state_t;

  state_t     state_r, state_nxt;
  in_item_t   item_r, item_nxt;
  logic [15:0] left_r, left_nxt;
  logic [3:0]  month_r, month_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r, out_nxt;

  year_ctrl_t  yctrl;
  logic [11:0] year;
  logic        leap;
  logic [8:0]  len;
  logic        gt;
  logic [15:0] diff;
  out_item_t   packed_res;

  dtf_year u_year (
    .clk  (clk),
    .rst_n(rst_n),
    .ctrl (yctrl),
    .year (year),
    .leap (leap)
  );

  assign len = (state_r == S_YEAR) ? (leap ? DaysLeapYear : DaysYear)
                                   : month_len(month_r, leap);

  dtf_sub u_sub (
    .left(left_r),
    .len (len),
    .gt  (gt),
    .diff(diff)
  );

  dtf_pack u_pack (
    .left (left_r),
    .month(month_r),
    .year (year),
    .item (item_r),
    .res  (packed_res)
  );

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    left_nxt      = left_r;
    month_nxt     = month_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    yctrl.init    = 1'b0;
    yctrl.step    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt   = in_item;
          left_nxt   = in_item.day_count;
          month_nxt  = MonthJan;
          yctrl.init = 1'b1;
          state_nxt  = S_YEAR;
        end
      end
      S_YEAR: begin
        if (gt) begin
          left_nxt   = diff;
          yctrl.step = 1'b1;
        end else begin
          state_nxt = S_MONTH;
        end
      end
      S_MONTH: begin
        if (month_r != MonthDec && gt) begin
          left_nxt  = diff;
          month_nxt = month_r + 4'd1;
        end else begin
          out_nxt       = packed_res;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      month_r     <= MonthJan;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      month_r     <= month_nxt;
    end
    item_r <= item_nxt;
    left_r <= left_nxt;
    out_r  <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == S_IDLE) && $past(state_r == S_MONTH))
    else $error("result shown outside month loop exit");

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MONTH) |-> (month_r >= MonthJan) && (month_r <= MonthDec))
    else $error("month counter out of range");

  a_out_year: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.year_number >= 12'(EpochYear)) &&
                  (out_item.year_number <= 12'd2157))
    else $error("result year out of range");

endmodule
